### src/mfsm_pkg.sv
// Shared types and constants of the magnetometer field strength monitor.
package mfsm_pkg;
	localparam int NumSensorsDefault = 4;
	localparam int SqSteps = 3;
	localparam int RootSteps = 13;
	localparam int DivSteps = 20;

	localparam logic [1:0] KIND_SHORT  = 2'd0;
	localparam logic [1:0] KIND_LONG   = 2'd1;
	localparam logic [1:0] KIND_SPREAD = 2'd2;

	localparam logic [2:0] REG_SHORT_WARN  = 3'd0;
	localparam logic [2:0] REG_SHORT_FAIL  = 3'd1;
	localparam logic [2:0] REG_LONG_WARN   = 3'd2;
	localparam logic [2:0] REG_LONG_FAIL   = 3'd3;
	localparam logic [2:0] REG_SPREAD_WARN = 3'd4;
	localparam logic [2:0] REG_SPREAD_FAIL = 3'd5;
	localparam logic [2:0] REG_MIN_US      = 3'd6;

	typedef struct packed {
		logic       load;
		logic       sq_step;
		logic       root_step;
		logic       upd_low;
		logic       upd_high;
		logic       eol_low;
		logic       eol_high;
		logic       div_init;
		logic       div_step;
		logic       spr_emit;
		logic       flush;
		logic [4:0] step;
		logic [3:0] idx;
	} cmd_t;

	typedef struct packed {
		logic in_eol;
		logic in_ok;
		logic out_free;
		logic seen;
	} stat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  sensor;
		logic        verdict;
		logic [12:0] ext;
		logic [12:0] lng;
		logic [47:0] t0;
		logic [47:0] t1;
		logic [15:0] pct;
	} res_t;
endpackage

### src/mfsm_ctrl.sv
// Sequencer of the magnetometer field strength monitor.
module mfsm_ctrl #(
	parameter int NUM_SENSORS = mfsm_pkg::NumSensorsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  mfsm_pkg::stat_t stat,
	output logic            in_ready,
	output mfsm_pkg::cmd_t  cmd
);
	typedef enum logic [3:0] {
		IDLE, SQ, ROOT, ULOW, UHIGH, ELOW, EHIGH, ECHK, EDIV, EEMIT, FLUSH
	} state_t;

	localparam logic [3:0] LastIdx = 4'(NUM_SENSORS - 1);

	state_t     state_q;
	logic [4:0] step_q;
	logic [3:0] idx_q;
	logic       idx_end;

	assign idx_end  = (idx_q == LastIdx);
	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		cmd.idx = idx_q;
		unique case (state_q)
			IDLE:  cmd.load = in_fire;
			SQ:    cmd.sq_step = 1'b1;
			ROOT:  cmd.root_step = 1'b1;
			ULOW:  cmd.upd_low = stat.out_free;
			UHIGH: cmd.upd_high = stat.out_free;
			ELOW:  cmd.eol_low = stat.out_free;
			EHIGH: cmd.eol_high = stat.out_free;
			ECHK:  cmd.div_init = stat.seen;
			EDIV:  cmd.div_step = 1'b1;
			EEMIT: cmd.spr_emit = stat.out_free;
			FLUSH: cmd.flush = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					step_q <= '0;
					idx_q <= '0;
					if (in_fire) begin
						if (stat.in_eol) state_q <= ELOW;
						else if (stat.in_ok) state_q <= SQ;
					end
				end
				SQ: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(mfsm_pkg::SqSteps - 1)) begin
						step_q <= '0;
						state_q <= ROOT;
					end
				end
				ROOT: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(mfsm_pkg::RootSteps - 1)) begin
						step_q <= '0;
						state_q <= ULOW;
					end
				end
				ULOW:  if (stat.out_free) state_q <= UHIGH;
				UHIGH: if (stat.out_free) state_q <= FLUSH;
				ELOW: if (stat.out_free) begin
					idx_q <= idx_end ? 4'd0 : idx_q + 4'd1;
					if (idx_end) state_q <= EHIGH;
				end
				EHIGH: if (stat.out_free) begin
					idx_q <= idx_end ? 4'd0 : idx_q + 4'd1;
					if (idx_end) state_q <= ECHK;
				end
				ECHK: begin
					step_q <= '0;
					if (stat.seen) state_q <= EDIV;
					else if (idx_end) state_q <= FLUSH;
					else idx_q <= idx_q + 4'd1;
				end
				EDIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(mfsm_pkg::DivSteps - 1)) state_q <= EEMIT;
				end
				EEMIT: if (stat.out_free) begin
					if (idx_end) state_q <= FLUSH;
					else begin
						idx_q <= idx_q + 4'd1;
						state_q <= ECHK;
					end
				end
				FLUSH: if (stat.out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### src/mfsm_dp.sv
// Datapath: sensor state, square root, percent divider and result registers.
module mfsm_dp #(
	parameter int NUM_SENSORS = mfsm_pkg::NumSensorsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mfsm_pkg::cmd_t  cmd,
	output mfsm_pkg::stat_t stat,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic [95:0]     s_tdata,
	input  logic [1:0]      s_tuser,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [143:0]    m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);
	localparam int SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	logic [12:0] short_warn_q, short_fail_q, long_warn_q, long_fail_q;
	logic [15:0] spread_warn_q, spread_fail_q;
	logic [31:0] min_us_q;

	logic        cmd_q;
	logic [1:0]  sens_q;
	logic [47:0] time_q;
	logic signed [12:0] x_q, y_q, z_q;
	logic [25:0] acc_q;
	logic [25:0] root_q;
	logic [12:0] len;

	logic [NUM_SENSORS-1:0] low_open_q, high_open_q, seen_q;
	logic [47:0] low_start_q  [NUM_SENSORS];
	logic [12:0] low_ext_q    [NUM_SENSORS];
	logic [47:0] high_start_q [NUM_SENSORS];
	logic [12:0] high_ext_q   [NUM_SENSORS];
	logic [12:0] short_q      [NUM_SENSORS];
	logic [12:0] long_q       [NUM_SENSORS];

	logic [19:0] num_q, quo_q;
	logic [13:0] rem_q;

	mfsm_pkg::res_t pend_q, out_q, gen;
	logic pend_v_q, out_v_q, last_q, gen_v;

	logic [SW-1:0] sel;
	logic [47:0]   dur_low, dur_high;
	logic          keep_low, keep_high;
	logic signed [12:0] comp;
	logic [25:0]   sq, bitv, trial;
	logic [13:0]   r2;
	logic [12:0]   sh, lg, diff;
	logic [15:0]   pct;
	logic          out_free;

	assign sel = cmd_q ? SW'(cmd.idx) : SW'(sens_q);
	assign len = root_q[12:0];
	assign out_free = !out_v_q || m_tready;
	assign sh = short_q[sel];
	assign lg = long_q[sel];
	assign diff = (lg >= sh) ? lg - sh : 13'd0;
	assign pct = (quo_q > 20'hFFFF) ? 16'hFFFF : quo_q[15:0];

	assign stat.in_eol = s_tuser[0];
	assign stat.in_ok = s_tuser[1] && (32'(s_tdata[1:0]) < NUM_SENSORS);
	assign stat.out_free = out_free;
	assign stat.seen = seen_q[sel];

	assign dur_low = time_q - low_start_q[sel];
	assign dur_high = time_q - high_start_q[sel];
	assign keep_low = dur_low >= {16'd0, min_us_q};
	assign keep_high = dur_high >= {16'd0, min_us_q};

	always_comb begin
		unique case (cmd.step[1:0])
			2'd0: comp = x_q;
			2'd1: comp = y_q;
			default: comp = z_q;
		endcase
	end
	assign sq = 26'(comp * comp);
	assign bitv = 26'd1 << (5'd24 - {cmd.step[3:0], 1'b0});
	assign trial = root_q + bitv;
	assign r2 = {rem_q[12:0], num_q[19]};

	always_comb begin
		gen_v = 1'b0;
		gen = '0;
		gen.sensor = 2'(sel);
		gen.t1 = time_q;
		if ((cmd.upd_low && low_open_q[sel] && len > short_warn_q) ||
			(cmd.eol_low && low_open_q[sel])) begin
			gen_v = keep_low;
			gen.kind = mfsm_pkg::KIND_SHORT;
			gen.verdict = low_ext_q[sel] < short_fail_q;
			gen.ext = low_ext_q[sel];
			gen.t0 = low_start_q[sel];
		end else if ((cmd.upd_high && high_open_q[sel] && len < long_warn_q) ||
			(cmd.eol_high && high_open_q[sel])) begin
			gen_v = keep_high;
			gen.kind = mfsm_pkg::KIND_LONG;
			gen.verdict = high_ext_q[sel] >= long_fail_q;
			gen.ext = high_ext_q[sel];
			gen.t0 = high_start_q[sel];
		end else if (cmd.spr_emit) begin
			gen.kind = mfsm_pkg::KIND_SPREAD;
			gen.ext = sh;
			gen.lng = lg;
			gen.t1 = '0;
			if (sh == 13'd0) begin
				gen_v = 1'b1;
				gen.verdict = 1'b1;
				gen.pct = 16'hFFFF;
			end else begin
				gen_v = pct >= spread_warn_q;
				gen.verdict = pct >= spread_fail_q;
				gen.pct = pct;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_warn_q <= 13'd120;
			short_fail_q <= 13'd100;
			long_warn_q <= 13'd550;
			long_fail_q <= 13'd600;
			spread_warn_q <= 16'd25;
			spread_fail_q <= 16'd35;
			min_us_q <= 32'd250000;
			low_open_q <= '0;
			high_open_q <= '0;
			seen_q <= '0;
			pend_q <= '0;
			out_q <= '0;
			last_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mfsm_pkg::REG_SHORT_WARN:  short_warn_q <= cfg_data[12:0];
					mfsm_pkg::REG_SHORT_FAIL:  short_fail_q <= cfg_data[12:0];
					mfsm_pkg::REG_LONG_WARN:   long_warn_q <= cfg_data[12:0];
					mfsm_pkg::REG_LONG_FAIL:   long_fail_q <= cfg_data[12:0];
					mfsm_pkg::REG_SPREAD_WARN: spread_warn_q <= cfg_data[15:0];
					mfsm_pkg::REG_SPREAD_FAIL: spread_fail_q <= cfg_data[15:0];
					mfsm_pkg::REG_MIN_US:      min_us_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_tready) out_v_q <= 1'b0;
			if (gen_v) begin
				pend_q <= gen;
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_q <= pend_q;
					last_q <= 1'b0;
					out_v_q <= 1'b1;
				end
			end
			if (cmd.flush && pend_v_q) begin
				out_q <= pend_q;
				last_q <= 1'b1;
				out_v_q <= 1'b1;
				pend_v_q <= 1'b0;
			end
			if (cmd.upd_low) begin
				seen_q[sel] <= 1'b1;
				if (!low_open_q[sel]) begin
					if (len <= short_warn_q) low_open_q[sel] <= 1'b1;
				end else if (len > short_warn_q) low_open_q[sel] <= 1'b0;
			end
			if (cmd.upd_high) begin
				if (!high_open_q[sel]) begin
					if (len >= long_warn_q) high_open_q[sel] <= 1'b1;
				end else if (len < long_warn_q) high_open_q[sel] <= 1'b0;
			end
			if (cmd.eol_low) low_open_q[sel] <= 1'b0;
			if (cmd.eol_high) high_open_q[sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= s_tuser[0];
			sens_q <= s_tdata[1:0];
			time_q <= s_tdata[49:2];
			x_q <= s_tdata[62:50];
			y_q <= s_tdata[75:63];
			z_q <= s_tdata[88:76];
			acc_q <= '0;
			root_q <= '0;
		end
		if (cmd.sq_step) acc_q <= acc_q + sq;
		if (cmd.root_step) begin
			if (acc_q >= trial) begin
				acc_q <= acc_q - trial;
				root_q <= (root_q >> 1) + bitv;
			end else begin
				root_q <= root_q >> 1;
			end
		end
		if (cmd.upd_low) begin
			if (!seen_q[sel]) begin
				short_q[sel] <= len;
				long_q[sel] <= len;
			end else begin
				if (len > long_q[sel]) long_q[sel] <= len;
				if (len < short_q[sel]) short_q[sel] <= len;
			end
			if (!low_open_q[sel]) begin
				if (len <= short_warn_q) begin
					low_start_q[sel] <= time_q;
					low_ext_q[sel] <= len;
				end
			end else if (len <= short_warn_q && len < low_ext_q[sel]) begin
				low_ext_q[sel] <= len;
			end
		end
		if (cmd.upd_high) begin
			if (!high_open_q[sel]) begin
				if (len >= long_warn_q) begin
					high_start_q[sel] <= time_q;
					high_ext_q[sel] <= len;
				end
			end else if (len >= long_warn_q && len > high_ext_q[sel]) begin
				high_ext_q[sel] <= len;
			end
		end
		if (cmd.div_init) begin
			num_q <= 20'(diff * 7'd100);
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (r2 >= {1'b0, sh}) begin
				rem_q <= r2 - {1'b0, sh};
				quo_q <= {quo_q[18:0], 1'b1};
			end else begin
				rem_q <= r2;
				quo_q <= {quo_q[18:0], 1'b0};
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast = last_q;
	assign m_tuser = out_q.kind;
	assign m_tdata = {3'd0, out_q.pct, out_q.t1, out_q.t0, out_q.lng, out_q.ext,
		out_q.verdict, out_q.sensor};
endmodule

### src/magnetometer_field_strength_monitor.sv
// Top level of the magnetometer field strength monitor.
// Input words on s_*: a field sample or an end-of-log marker. Each valid
// sample gets its field length by an iterative square root and may open or
// close a short or long incident. End of log closes all open incidents and
// checks each seen sensor's spread in percent by an iterative divider.
// Results leave on m_* with tlast on the final result of an input word.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while the block is idle; the block itself
// does not enforce it. One word is taken at a time. A sample passes
// through accept, 3 squaring steps, 13 root steps, two update steps and
// a flush; an end-of-log word closes each sensor's incidents, runs the
// one-bit-per-cycle divider per seen sensor and flushes.
// Results pass through a one-deep pending register and the output
// register; a stalled receiver holds the sequencer until the output frees.
// Reset clears all incidents, seen flags and outputs and restores the
// default thresholds.
module magnetometer_field_strength_monitor #(
	parameter int NUM_SENSORS = mfsm_pkg::NumSensorsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // sensor_index, time_us, field_x, field_y, field_z
	input  logic [1:0]   s_tuser,  // cmd, field_valid
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // report_sensor, verdict, extreme_length,
	                               // longest_length, start_time, stop_time, spread_percent
	output logic [1:0]   m_tuser,  // report_kind
	output logic         m_tlast
);
	mfsm_pkg::cmd_t  cmd;
	mfsm_pkg::stat_t stat;
	logic in_fire;

	assign in_fire = s_tvalid && s_tready;

	mfsm_ctrl #(.NUM_SENSORS(NUM_SENSORS)) u_ctrl (
		.clk, .arst_n, .in_fire, .stat, .in_ready(s_tready), .cmd
	);

	mfsm_dp #(.NUM_SENSORS(NUM_SENSORS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
		.s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (s_tuser[0] || stat.in_ok) |=> !s_tready)
		else $error("word accepted while busy");
	a_spread_times: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mfsm_pkg::KIND_SPREAD |-> m_tdata[124:29] == '0)
		else $error("spread report carries times");
	a_incident_pct: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != mfsm_pkg::KIND_SPREAD |-> m_tdata[140:125] == '0)
		else $error("incident report carries percent");
endmodule
